### rtl/core/epoch_seconds_to_calendar_macros.svh
// Assertion macros for the calendar converter top level
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define ESC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define ESC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/esc_pkg.sv
// Types, constants and tables of the epoch seconds to calendar converter
package esc_pkg;

  // Time zone register reset: three hours east of UTC
  localparam logic [16:0] ZONE_RESET = 17'd10800;

  // Seconds per day and its reciprocal estimate (quotient exact or one low)
  localparam logic [16:0] DAY_SECS  = 17'd86400;
  localparam logic [31:0] DAY_MUL   = 32'((64'd1 << 48) / 64'd86400);
  localparam int          DAY_SHIFT = 48;

  // Exact reciprocals: M = ceil(2^k / d) with k = input bits + ceil(log2 d)
  localparam logic [17:0] TOD_MUL  = 18'((2**23 + 59) / 60);    // 17-bit tod / 60
  localparam logic [11:0] MT_MUL   = 12'((2**17 + 59) / 60);    // 11-bit minutes / 60
  localparam logic [18:0] Q4Y_MUL  = 19'((2**29 + 1459) / 1460); // 18-bit / 1460
  localparam logic [18:0] YEAR_MUL = 19'((2**27 + 364) / 365);  // 18-bit / 365
  localparam logic [11:0] MON_MUL  = 12'((2**19 + 152) / 153);  // 11-bit / 153
  localparam logic [16:0] WEEK_MUL = 17'((2**19 + 6) / 7);      // 16-bit / 7

  // Day count relative to 1600-03-01, start of a 400-year cycle
  localparam logic [17:0] ERA_DAYS   = 18'd146097;
  localparam logic [17:0] EPOCH_BIAS = 18'd135080;
  localparam logic [15:0] ERA_SPLIT  = 16'(146097 - 135080);
  localparam logic [17:0] CENT_DAYS  = 18'd36524;
  localparam logic [11:0] BASE_YEAR  = 12'd1600;
  localparam logic [11:0] ERA_YEARS  = 12'd400;

  // 1970-01-01 was a Thursday; Monday is zero
  localparam logic [15:0] WEEK_BIAS = 16'd3;

  // Pipeline depths
  localparam int SPLIT_LAT = 4;
  localparam int TOD_LAT   = 3;
  localparam int DATE_LAT  = 8;
  localparam int HMS_DLY   = DATE_LAT - TOD_LAT;
  localparam int PIPE_LAT  = SPLIT_LAT + DATE_LAT;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } hms_t;

  typedef struct packed {
    logic [2:0]  weekday;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } date_t;

  // Days in the March-based year before month index mp (0 is March)
  function automatic logic [8:0] days_before(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

### rtl/core/esc_date.sv
// Pipelined civil date and weekday from a day count since 1970-01-01
module esc_date (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [15:0]    in_days,
  output logic           out_valid,
  output esc_pkg::date_t out_date
);

  logic [esc_pkg::DATE_LAT-1:0] v_r;

  // stage 1
  logic        d1_era_r;
  logic [17:0] d1_doe_r;
  logic [15:0] d1_w_r;
  logic        era_nxt;
  logic [17:0] doe_nxt;

  // stage 2
  logic [17:0] d2_doe_r;
  logic        d2_era_r;
  logic [6:0]  d2_q4y_r;
  logic [2:0]  d2_cent_r;
  logic        d2_last_r;
  logic [15:0] d2_w_r;
  logic [12:0] d2_wq_r;
  logic [36:0] q4y_prod;
  logic [32:0] wk_prod;
  logic [2:0]  cent_nxt;

  // stage 3
  logic [17:0] d3_num_r;
  logic [17:0] d3_doe_r;
  logic        d3_era_r;
  logic [2:0]  d3_wd_r;
  logic [17:0] num_nxt;
  logic [15:0] wd_full;

  // stage 4
  logic [8:0]  d4_yoe_r;
  logic [17:0] d4_doe_r;
  logic        d4_era_r;
  logic [2:0]  d4_wd_r;
  logic [36:0] yr_prod;

  // stage 5
  logic [17:0] d5_t_r;
  logic [17:0] d5_doe_r;
  logic [8:0]  d5_yoe_r;
  logic        d5_era_r;
  logic [2:0]  d5_wd_r;
  logic [1:0]  c100;
  logic [17:0] t_nxt;

  // stage 6
  logic [8:0]  d6_doy_r;
  logic [8:0]  d6_yoe_r;
  logic        d6_era_r;
  logic [2:0]  d6_wd_r;
  logic [17:0] doy_full;

  // stage 7
  logic [3:0]  d7_mp_r;
  logic [8:0]  d7_doy_r;
  logic [8:0]  d7_yoe_r;
  logic        d7_era_r;
  logic [2:0]  d7_wd_r;
  logic [10:0] mon_num;
  logic [22:0] mon_prod;

  // stage 8
  esc_pkg::date_t date_r;
  esc_pkg::date_t date_nxt;
  logic [8:0]     day_full;
  logic           jan_feb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[esc_pkg::DATE_LAT-2:0], in_valid};
    end
  end

  // Fold the epoch into a 400-year cycle starting 1600-03-01
  always_comb begin
    era_nxt = (in_days >= esc_pkg::ERA_SPLIT);
    if (era_nxt) begin
      doe_nxt = {2'd0, in_days - esc_pkg::ERA_SPLIT};
    end else begin
      doe_nxt = {2'd0, in_days} + esc_pkg::EPOCH_BIAS;
    end
  end

  assign q4y_prod = {19'd0, d1_doe_r} * {18'd0, esc_pkg::Q4Y_MUL};
  assign wk_prod  = {17'd0, d1_w_r} * {16'd0, esc_pkg::WEEK_MUL};
  assign cent_nxt = 3'(d1_doe_r >= esc_pkg::CENT_DAYS)
                  + 3'(d1_doe_r >= 18'(2 * 36524))
                  + 3'(d1_doe_r >= 18'(3 * 36524))
                  + 3'(d1_doe_r >= esc_pkg::ERA_DAYS - 18'd1);

  // Remove leap days so a plain divide by 365 gives the year of the cycle
  assign num_nxt = d2_doe_r - {11'd0, d2_q4y_r} + {15'd0, d2_cent_r}
                 - {17'd0, d2_last_r};
  assign wd_full = d2_w_r - ({3'd0, d2_wq_r} * 16'd7);

  assign yr_prod = {19'd0, d3_num_r} * {18'd0, esc_pkg::YEAR_MUL};

  assign c100  = 2'(d4_yoe_r >= 9'd100) + 2'(d4_yoe_r >= 9'd200)
               + 2'(d4_yoe_r >= 9'd300);
  assign t_nxt = ({9'd0, d4_yoe_r} * 18'd365) + {11'd0, d4_yoe_r[8:2]}
               - {16'd0, c100};

  assign doy_full = d5_doe_r - d5_t_r;

  assign mon_num  = ({2'd0, d6_doy_r} * 11'd5) + 11'd2;
  assign mon_prod = {12'd0, mon_num} * {11'd0, esc_pkg::MON_MUL};

  always_comb begin
    jan_feb          = (d7_mp_r >= 4'd10);
    day_full         = d7_doy_r - esc_pkg::days_before(d7_mp_r) + 9'd1;
    date_nxt.weekday = d7_wd_r;
    date_nxt.day     = day_full[4:0];
    date_nxt.month   = jan_feb ? (d7_mp_r - 4'd9) : (d7_mp_r + 4'd3);
    date_nxt.year    = esc_pkg::BASE_YEAR + {3'd0, d7_yoe_r}
                     + (d7_era_r ? esc_pkg::ERA_YEARS : 12'd0)
                     + {11'd0, jan_feb};
  end

  always_ff @(posedge clk) begin
    d1_era_r  <= era_nxt;
    d1_doe_r  <= doe_nxt;
    d1_w_r    <= in_days + esc_pkg::WEEK_BIAS;

    d2_doe_r  <= d1_doe_r;
    d2_era_r  <= d1_era_r;
    d2_q4y_r  <= q4y_prod[35:29];
    d2_cent_r <= cent_nxt;
    d2_last_r <= (d1_doe_r == esc_pkg::ERA_DAYS - 18'd1);
    d2_w_r    <= d1_w_r;
    d2_wq_r   <= wk_prod[31:19];

    d3_num_r  <= num_nxt;
    d3_doe_r  <= d2_doe_r;
    d3_era_r  <= d2_era_r;
    d3_wd_r   <= wd_full[2:0];

    d4_yoe_r  <= yr_prod[35:27];
    d4_doe_r  <= d3_doe_r;
    d4_era_r  <= d3_era_r;
    d4_wd_r   <= d3_wd_r;

    d5_t_r    <= t_nxt;
    d5_doe_r  <= d4_doe_r;
    d5_yoe_r  <= d4_yoe_r;
    d5_era_r  <= d4_era_r;
    d5_wd_r   <= d4_wd_r;

    d6_doy_r  <= doy_full[8:0];
    d6_yoe_r  <= d5_yoe_r;
    d6_era_r  <= d5_era_r;
    d6_wd_r   <= d5_wd_r;

    d7_mp_r   <= mon_prod[22:19];
    d7_doy_r  <= d6_doy_r;
    d7_yoe_r  <= d6_yoe_r;
    d7_era_r  <= d6_era_r;
    d7_wd_r   <= d6_wd_r;

    date_r    <= date_nxt;
  end

  assign out_valid = v_r[esc_pkg::DATE_LAT-1];
  assign out_date  = date_r;

endmodule

### rtl/core/epoch_seconds_to_calendar.sv
// Top level: UTC seconds to local calendar date and time of day
//
//  channel  handshake         payload
//  in       start / busy      in_utc_seconds
//  out      out_strobe        out_second .. out_year
//  cfg      cfg_we            cfg_wdata (zone offset, signed seconds)
//
// One transaction enters per cycle; each result passes through the day split
// (4 stages) and then the date path (8 stages).
// Synchronous reset clears the valid bits and loads the zone offset with
// three hours; busy is high only while reset is held.
// The receiver cannot stall, so the pipeline advances every cycle.
module epoch_seconds_to_calendar (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_utc_seconds,
  input  logic               cfg_we,
  input  logic signed [16:0] cfg_wdata,
  output logic               out_strobe,
  output logic [5:0]         out_second,
  output logic [5:0]         out_minute,
  output logic [4:0]         out_hour,
  output logic [2:0]         out_weekday,
  output logic [4:0]         out_day,
  output logic [3:0]         out_month,
  output logic [11:0]        out_year
);

  logic [16:0] zone_r;
  logic        v1_r, v2_r, v3_r, v4_r;

  logic [31:0] local_r, local2_r, local3_r;
  logic [31:0] local_nxt;
  logic [63:0] day_prod;
  logic [15:0] qest_r, qest3_r;
  logic [31:0] qm_r;
  logic [31:0] qm_nxt;
  logic [31:0] rem_full;
  logic [17:0] rem;
  logic        day_fix;
  logic [15:0] days_r, days_nxt;
  logic [16:0] tod_r, tod_nxt;

  logic [34:0] mt_prod;
  logic [10:0] mt_r, mt6_r;
  logic [16:0] tod5_r;
  logic [16:0] sec_full;
  logic [22:0] hour_prod;
  logic [5:0]  sec_r;
  logic [4:0]  hour_r;
  logic [10:0] min_full;
  esc_pkg::hms_t hms_r, hms_nxt;
  esc_pkg::hms_t hms_dly_r [esc_pkg::HMS_DLY];

  logic           date_valid;
  esc_pkg::date_t date;

  assign busy = !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= esc_pkg::ZONE_RESET;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        zone_r <= cfg_wdata;
      end
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Local count wraps modulo 2^32
  assign local_nxt = in_utc_seconds + {{15{zone_r[16]}}, zone_r};

  // Quotient estimate by reciprocal; it is exact or one low
  assign day_prod = {32'd0, local_r} * {32'd0, esc_pkg::DAY_MUL};
  assign qm_nxt   = {16'd0, qest_r} * {15'd0, esc_pkg::DAY_SECS};

  always_comb begin
    rem_full = local3_r - qm_r;
    rem      = rem_full[17:0];
    day_fix  = (rem >= {1'b0, esc_pkg::DAY_SECS});
    if (day_fix) begin
      days_nxt = qest3_r + 16'd1;
      tod_nxt  = 17'(rem - {1'b0, esc_pkg::DAY_SECS});
    end else begin
      days_nxt = qest3_r;
      tod_nxt  = rem[16:0];
    end
  end

  // Time of day: minutes of day, then split into h:m:s
  assign mt_prod   = {18'd0, tod_r} * {17'd0, esc_pkg::TOD_MUL};
  assign sec_full  = tod5_r - ({6'd0, mt_r} * 17'd60);
  assign hour_prod = {12'd0, mt_r} * {11'd0, esc_pkg::MT_MUL};
  assign min_full  = mt6_r - ({6'd0, hour_r} * 11'd60);

  always_comb begin
    hms_nxt.second = sec_r;
    hms_nxt.minute = min_full[5:0];
    hms_nxt.hour   = hour_r;
  end

  always_ff @(posedge clk) begin
    local_r  <= local_nxt;
    qest_r   <= day_prod[esc_pkg::DAY_SHIFT+15:esc_pkg::DAY_SHIFT];
    local2_r <= local_r;
    qm_r     <= qm_nxt;
    qest3_r  <= qest_r;
    local3_r <= local2_r;
    days_r   <= days_nxt;
    tod_r    <= tod_nxt;

    mt_r     <= mt_prod[33:23];
    tod5_r   <= tod_r;
    sec_r    <= sec_full[5:0];
    hour_r   <= hour_prod[21:17];
    mt6_r    <= mt_r;
    hms_r    <= hms_nxt;

    // Hold time of day until the date path catches up
    hms_dly_r[0] <= hms_r;
    for (int i = 1; i < esc_pkg::HMS_DLY; i++) begin
      hms_dly_r[i] <= hms_dly_r[i-1];
    end
  end

  esc_date u_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_days   (days_r),
    .out_valid (date_valid),
    .out_date  (date)
  );

  assign out_strobe  = date_valid;
  assign out_second  = hms_dly_r[esc_pkg::HMS_DLY-1].second;
  assign out_minute  = hms_dly_r[esc_pkg::HMS_DLY-1].minute;
  assign out_hour    = hms_dly_r[esc_pkg::HMS_DLY-1].hour;
  assign out_weekday = date.weekday;
  assign out_day     = date.day;
  assign out_month   = date.month;
  assign out_year    = date.year;

`include "epoch_seconds_to_calendar_macros.svh"

  `ESC_ASSERT_IMPLIES(a_result_latency, clk, rst_n, out_strobe, $past(start && !busy, esc_pkg::PIPE_LAT), "result without a transaction at the pipeline depth")
  `ESC_ASSERT_IMPLIES(a_time_range, clk, rst_n, out_strobe, (out_second < 6'd60) && (out_minute < 6'd60) && (out_hour < 5'd24), "time of day out of range")
  `ESC_ASSERT_IMPLIES(a_date_range, clk, rst_n, out_strobe, (out_weekday < 3'd7) && (out_day != 5'd0) && (out_month != 4'd0) && (out_month < 4'd13), "date field out of range")

endmodule
